// ===== src/hfe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package hfe_pkg;

   typedef struct packed {
      logic signed [23:0] x_point;
      logic               last_point;
   } req_type;

   typedef struct packed {
      logic [5:0]         order_index;
      logic signed [31:0] func_value;
      logic signed [31:0] func_slope;
      logic               last_order;
      logic               final_point;
   } rsp_type;

   typedef struct packed {
      logic signed [23:0] x_point;
      logic signed [31:0] psi0;
      logic               final_point;
   } job_type;

   typedef logic [63:0][31:0] coef_rom_type;

   localparam logic [1:0] COEF_C1 = 2'd0;
   localparam logic [1:0] COEF_C2 = 2'd1;
   localparam logic [1:0] COEF_C3 = 2'd2;

   localparam logic [47:0] FLUSH_LIMIT  = 48'd22 << 37;
   localparam logic [31:0] PI_QUARTER   = 32'd806514912;
   localparam logic [4:0]  LAST_TERM    = 5'd24;
   localparam logic [2:0]  SQUARINGS    = 3'd5;

   function automatic logic [31:0] root_floor(input logic [63:0] num, input logic [63:0] den);
      logic [31:0]  r;
      logic [31:0]  t;
      logic [127:0] sq;
      r = '0;
      for (int b = 31; b >= 0; b--) begin
         t  = r | (32'd1 << b);
         sq = 128'(t) * 128'(t) * 128'(den);
         if (sq <= 128'(num)) begin
            r = t;
         end
      end
      return r;
   endfunction

   function automatic coef_rom_type build_coef(input logic [1:0] sel);
      coef_rom_type rom;
      for (int j = 0; j < 64; j++) begin
         if (sel == COEF_C1) begin
            rom[j] = root_floor(64'(j) << 55, 64'd1);
         end else if (sel == COEF_C2) begin
            rom[j] = root_floor(64'd1 << 57, 64'(j + 1));
         end else begin
            rom[j] = root_floor(64'(j) << 53, 64'd1);
         end
      end
      return rom;
   endfunction

   localparam coef_rom_type C1_ROM = build_coef(COEF_C1);
   localparam coef_rom_type C2_ROM = build_coef(COEF_C2);
   localparam coef_rom_type C3_ROM = build_coef(COEF_C3);

   function automatic logic [32:0] recip_of(input logic [4:0] k);
      logic [32:0] r;
      unique case (k)
         5'd1:    r = 33'd4294967296;
         5'd2:    r = 33'd2147483648;
         5'd3:    r = 33'd1431655765;
         5'd4:    r = 33'd1073741824;
         5'd5:    r = 33'd858993459;
         5'd6:    r = 33'd715827882;
         5'd7:    r = 33'd613566756;
         5'd8:    r = 33'd536870912;
         5'd9:    r = 33'd477218588;
         5'd10:   r = 33'd429496729;
         5'd11:   r = 33'd390451572;
         5'd12:   r = 33'd357913941;
         5'd13:   r = 33'd330382099;
         5'd14:   r = 33'd306783378;
         5'd15:   r = 33'd286331153;
         5'd16:   r = 33'd268435456;
         5'd17:   r = 33'd252645135;
         5'd18:   r = 33'd238609294;
         5'd19:   r = 33'd226050910;
         5'd20:   r = 33'd214748364;
         5'd21:   r = 33'd204522252;
         5'd22:   r = 33'd195225786;
         5'd23:   r = 33'd186737708;
         5'd24:   r = 33'd178956970;
         default: r = 33'd0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== src/hfe_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hfe_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire hfe_pkg::req_type req_data,
   output logic                  push,
   input  wire logic             full,
   output hfe_pkg::job_type      job
);

   typedef enum logic [3:0] {
      F_IDLE, F_SQ, F_CHECK, F_TP, F_TQ, F_TC, F_SQR, F_SCL, F_PUSH
   } front_state_type;

   front_state_type    state_ff, state_in;
   logic signed [23:0] x_ff, x_in;
   logic               fin_ff, fin_in;
   logic [47:0]        q_ff, q_in;
   logic [31:0]        s_ff, s_in;
   logic [32:0]        term_ff, term_in;
   logic [31:0]        p_ff, p_in;
   logic [31:0]        qh_ff, qh_in;
   logic signed [35:0] acc_ff, acc_in;
   logic [4:0]         k_ff, k_in;
   logic [32:0]        e_ff, e_in;
   logic [2:0]         n_ff, n_in;
   logic signed [31:0] psi_ff, psi_in;

   logic [64:0]        prod_a;
   logic [64:0]        prod_b;
   logic [37:0]        rem;
   logic [31:0]        t_val;
   logic signed [35:0] acc_next;
   logic [65:0]        sq;
   logic [64:0]        scl;

   always_comb begin
      prod_a   = 65'(term_ff) * 65'(s_ff);
      prod_b   = 65'(p_ff) * 65'(hfe_pkg::recip_of(k_ff));
      rem      = 38'(p_ff) - 38'(qh_ff) * 38'(k_ff);
      t_val    = (rem >= 38'(k_ff)) ? qh_ff + 32'd1 : qh_ff;
      acc_next = k_ff[0] ? acc_ff - 36'(t_val) : acc_ff + 36'(t_val);
      sq       = 66'(e_ff) * 66'(e_ff) + (66'd1 << 31);
      scl      = 65'(e_ff) * 65'(hfe_pkg::PI_QUARTER) + (65'd1 << 31);
   end

   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      fin_in   = fin_ff;
      q_in     = q_ff;
      s_in     = s_ff;
      term_in  = term_ff;
      p_in     = p_ff;
      qh_in    = qh_ff;
      acc_in   = acc_ff;
      k_in     = k_ff;
      e_in     = e_ff;
      n_in     = n_ff;
      psi_in   = psi_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               x_in     = req_data.x_point;
               fin_in   = req_data.last_point;
               state_in = F_SQ;
            end
         end
         F_SQ: begin
            q_in     = 48'(x_ff) * 48'(x_ff);
            state_in = F_CHECK;
         end
         F_CHECK: begin
            if (q_ff >= hfe_pkg::FLUSH_LIMIT) begin
               psi_in   = '0;
               state_in = F_PUSH;
            end else begin
               s_in     = q_ff[41:10];
               term_in  = 33'd1 << 32;
               acc_in   = 36'sd1 <<< 32;
               k_in     = 5'd1;
               state_in = F_TP;
            end
         end
         F_TP: begin
            p_in     = prod_a[63:32];
            state_in = F_TQ;
         end
         F_TQ: begin
            qh_in    = prod_b[63:32];
            state_in = F_TC;
         end
         F_TC: begin
            term_in = 33'(t_val);
            acc_in  = acc_next;
            if (k_ff == hfe_pkg::LAST_TERM) begin
               if (acc_next < 36'sd0) begin
                  e_in = '0;
               end else if (acc_next > (36'sd1 <<< 32)) begin
                  e_in = 33'd1 << 32;
               end else begin
                  e_in = acc_next[32:0];
               end
               n_in     = '0;
               state_in = F_SQR;
            end else begin
               k_in     = k_ff + 5'd1;
               state_in = F_TP;
            end
         end
         F_SQR: begin
            if (!e_ff[32]) begin
               e_in = sq[64:32];
            end
            n_in = n_ff + 3'd1;
            if (n_ff == hfe_pkg::SQUARINGS - 3'd1) begin
               state_in = F_SCL;
            end
         end
         F_SCL: begin
            psi_in   = signed'(scl[63:32]);
            state_in = F_PUSH;
         end
         F_PUSH: begin
            if (!full) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      x_ff    <= x_in;
      fin_ff  <= fin_in;
      q_ff    <= q_in;
      s_ff    <= s_in;
      term_ff <= term_in;
      p_ff    <= p_in;
      qh_ff   <= qh_in;
      acc_ff  <= acc_in;
      k_ff    <= k_in;
      e_ff    <= e_in;
      n_ff    <= n_in;
      psi_ff  <= psi_in;
   end

   assign req_stall       = (state_ff != F_IDLE);
   assign push            = (state_ff == F_PUSH) && !full;
   assign job.x_point     = x_ff;
   assign job.psi0        = psi_ff;
   assign job.final_point = fin_ff;

endmodule
`default_nettype wire

// ===== src/hfe_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hfe_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire hfe_pkg::job_type wr_data,
   output logic                  full,
   input  wire logic             pop,
   output hfe_pkg::job_type      rd_data,
   output logic                  empty
);

   hfe_pkg::job_type mem_ff [2];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign rd_data = mem_ff[rd_ptr_ff];
   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);

endmodule
`default_nettype wire

// ===== src/hfe_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hfe_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [6:0]       order_count,
   input  wire logic             empty,
   output logic                  pop,
   input  wire hfe_pkg::job_type job,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output hfe_pkg::rsp_type      rsp_data
);

   typedef enum logic [2:0] {
      B_IDLE, B_MUL, B_SUB, B_MUL2, B_NEXT
   } back_state_type;

   back_state_type     state_ff;
   logic signed [23:0] x_ff;
   logic signed [31:0] cur_ff;
   logic signed [31:0] prev_ff;
   logic [5:0]         j_ff;
   logic [6:0]         m_ff;
   logic               fin_ff;
   logic signed [55:0] m1_ff;
   logic signed [63:0] m2_ff;
   logic signed [63:0] m3_ff;
   logic signed [35:0] d_ff;
   logic signed [68:0] m4_ff;
   logic               out_valid_ff;
   hfe_pkg::rsp_type   out_ff;

   logic signed [32:0] c1s, c2s, c3s;
   logic signed [56:0] a_full;
   logic signed [64:0] b_full;
   logic signed [65:0] d_raw;
   logic signed [35:0] d_sat;
   logic signed [64:0] s1_full;
   logic signed [56:0] s2_full;
   logic signed [65:0] sl_raw;
   logic signed [31:0] sl_sat;
   logic signed [69:0] n_full;
   logic signed [31:0] n_sat;
   logic               out_free;
   logic               is_last;

   always_comb begin
      c1s     = signed'({1'b0, hfe_pkg::C1_ROM[j_ff]});
      c2s     = signed'({1'b0, hfe_pkg::C2_ROM[j_ff]});
      c3s     = signed'({1'b0, hfe_pkg::C3_ROM[j_ff]});
      a_full  = (57'(m1_ff) + 57'sd131072) >>> 18;
      b_full  = (65'(m3_ff) + 65'sd134217728) >>> 28;
      d_raw   = 66'(a_full) - 66'(b_full);
      if (d_raw > (66'sd1 <<< 34)) begin
         d_sat = 36'sd1 <<< 34;
      end else if (d_raw < -(66'sd1 <<< 34)) begin
         d_sat = -(36'sd1 <<< 34);
      end else begin
         d_sat = d_raw[35:0];
      end
      s1_full = (65'(m2_ff) + 65'sd1073741824) >>> 31;
      s2_full = (57'(m1_ff) + 57'sd4194304) >>> 23;
      sl_raw  = 66'(s1_full) - 66'(s2_full);
      if (sl_raw > 66'sd2147483647) begin
         sl_sat = 32'sh7FFFFFFF;
      end else if (sl_raw < -66'sd2147483648) begin
         sl_sat = 32'sh80000000;
      end else begin
         sl_sat = sl_raw[31:0];
      end
      n_full  = (70'(m4_ff) + 70'sd134217728) >>> 28;
      if (n_full > 70'sd2147483647) begin
         n_sat = 32'sh7FFFFFFF;
      end else if (n_full < -70'sd2147483648) begin
         n_sat = 32'sh80000000;
      end else begin
         n_sat = n_full[31:0];
      end
      out_free = !out_valid_ff || !rsp_stall;
      is_last  = ({1'b0, j_ff} + 7'd1) == m_ff;
   end

   assign pop = (state_ff == B_IDLE) && !empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         if ((state_ff == B_SUB) && out_free) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            B_IDLE: begin
               if (!empty) begin
                  x_ff     <= job.x_point;
                  cur_ff   <= job.psi0;
                  prev_ff  <= '0;
                  fin_ff   <= job.final_point;
                  j_ff     <= '0;
                  m_ff     <= order_count;
                  state_ff <= B_MUL;
               end
            end
            B_MUL: begin
               m1_ff    <= 56'(x_ff) * 56'(cur_ff);
               m2_ff    <= 64'(c3s) * 64'(prev_ff);
               m3_ff    <= 64'(c1s) * 64'(prev_ff);
               state_ff <= B_SUB;
            end
            B_SUB: begin
               if (out_free) begin
                  out_ff.order_index <= j_ff;
                  out_ff.func_value  <= cur_ff;
                  out_ff.func_slope  <= sl_sat;
                  out_ff.last_order  <= is_last;
                  out_ff.final_point <= fin_ff;
                  d_ff               <= d_sat;
                  state_ff           <= is_last ? B_IDLE : B_MUL2;
               end
            end
            B_MUL2: begin
               m4_ff    <= 69'(c2s) * 69'(d_ff);
               state_ff <= B_NEXT;
            end
            B_NEXT: begin
               prev_ff  <= cur_ff;
               cur_ff   <= n_sat;
               j_ff     <= j_ff + 6'd1;
               state_ff <= B_MUL;
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule
`default_nettype wire

// ===== src/hermite_function_evaluator_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_stall  req_data  (hfe_pkg::req_type)
// rsp       out        rsp_valid / rsp_stall  rsp_data  (hfe_pkg::rsp_type)
// csr       in         csr_valid / csr_ready  csr_data  (num_functions, 7 bits)
//
// The front takes one request at a time: squaring, flush check, 24 series terms (each in F_TP,
// F_TQ, F_TC), five squarings, one scale and one push, then idle; flushed points go from the
// check straight to the push. The back pops a job, then runs B_MUL, B_SUB, B_MUL2 and B_NEXT
// per order (B_MUL and B_SUB only for the last); a two-entry queue sits between them.
// Reset is synchronous; num_functions returns to 64.
// A stalled result holds the back; a full queue holds the front.
module hermite_function_evaluator_core #(
   parameter int MAX_FUNCTIONS = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire hfe_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output hfe_pkg::rsp_type      rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [6:0]       csr_data
);

   localparam logic [6:0] MaxCount = 7'(MAX_FUNCTIONS);

   logic [6:0]       nf_ff;
   logic [6:0]       order_count;
   logic             push;
   logic             full;
   logic             pop;
   logic             empty;
   hfe_pkg::job_type wr_job;
   hfe_pkg::job_type rd_job;

   always_ff @(posedge clock) begin
      if (reset) begin
         nf_ff <= 7'd64;
      end else if (csr_valid) begin
         nf_ff <= csr_data;
      end
   end

   assign csr_ready = 1'b1;

   always_comb begin
      if (nf_ff == 7'd0) begin
         order_count = 7'd1;
      end else if (nf_ff > MaxCount) begin
         order_count = MaxCount;
      end else begin
         order_count = nf_ff;
      end
   end

   hfe_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .push      (push),
      .full      (full),
      .job       (wr_job)
   );

   hfe_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data (wr_job),
      .full    (full),
      .pop     (pop),
      .rd_data (rd_job),
      .empty   (empty)
   );

   hfe_back u_back (
      .clock       (clock),
      .reset       (reset),
      .order_count (order_count),
      .empty       (empty),
      .pop         (pop),
      .job         (rd_job),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule
`default_nettype wire

// ===== test/tb_hermite_function_evaluator_core.sv =====
`timescale 1ns / 1ps
class hermite_scoreboard;
   hfe_pkg::rsp_type pending[$];
   int unsigned      orders = 64;
   int               errors = 0;

   static function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned r = 0;
      longint unsigned b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   static function longint round_shift(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   static function longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   static function longint gaussian_seed(longint x);
      longint unsigned q, s, term, e;
      longint          acc;
      q = longint'(x * x);
      if (q >= (64'd22 << 37)) return 0;
      s    = q >> 10;
      term = 64'd1 << 32;
      acc  = 64'sd1 << 32;
      for (int k = 1; k <= 24; k++) begin
         term = ((term * s) >> 32) / k;
         if (k % 2 == 1) acc -= longint'(term);
         else acc += longint'(term);
      end
      e = longint'(clip(acc, 0, 64'sd1 << 32));
      for (int k = 0; k < 5; k++)
         if (e < (64'd1 << 32)) e = (e * e + (64'd1 << 31)) >> 32;
      return longint'((e * 64'd806514912 + (64'd1 << 31)) >> 32);
   endfunction

   function void note_request(hfe_pkg::req_type r);
      longint           x, prev, cur, c1, c2, c3, a, b, d, slope;
      longint           lo, hi;
      int unsigned      m;
      hfe_pkg::rsp_type e;
      lo   = -64'sd2147483648;
      hi   = 64'sd2147483647;
      x    = longint'(r.x_point);
      m    = (orders == 0) ? 1 : (orders > 64 ? 64 : orders);
      prev = 0;
      cur  = gaussian_seed(x);
      for (int j = 0; j < m; j++) begin
         c1    = longint'(int_sqrt(64'(j) << 55));
         c2    = longint'(int_sqrt((64'd1 << 57) / 64'(j + 1)));
         c3    = longint'(int_sqrt(64'(j) << 53));
         slope = clip(round_shift(c3 * prev, 31) - round_shift(x * cur, 23), lo, hi);
         e.order_index = j[5:0];
         e.func_value  = cur[31:0];
         e.func_slope  = slope[31:0];
         e.last_order  = (j + 1 == m);
         e.final_point = r.last_point;
         pending.push_back(e);
         a    = round_shift(x * cur, 18);
         b    = round_shift(c1 * prev, 28);
         d    = clip(a - b, -(64'sd1 <<< 34), 64'sd1 <<< 34);
         prev = cur;
         cur  = clip(round_shift(c2 * d, 28), lo, hi);
      end
   endfunction

   function void check_result(hfe_pkg::rsp_type got);
      hfe_pkg::rsp_type e;
      if (pending.size() == 0) begin
         $error("unexpected result order %0d", got.order_index);
         errors++;
         return;
      end
      e = pending.pop_front();
      if (got.order_index !== e.order_index) begin
         $error("order_index exp %0d got %0d", e.order_index, got.order_index);
         errors++;
      end
      if (got.func_value !== e.func_value) begin
         $error("func_value exp %0d got %0d", e.func_value, got.func_value);
         errors++;
      end
      if (got.func_slope !== e.func_slope) begin
         $error("func_slope exp %0d got %0d", e.func_slope, got.func_slope);
         errors++;
      end
      if (got.last_order !== e.last_order) begin
         $error("last_order exp %0d got %0d", e.last_order, got.last_order);
         errors++;
      end
      if (got.final_point !== e.final_point) begin
         $error("final_point exp %0d got %0d", e.final_point, got.final_point);
         errors++;
      end
   endfunction
endclass

module tb_hermite_function_evaluator_core;

   localparam int DRAIN_CYCLES = 400;
   localparam int STALL_LIMIT  = 20000;
   localparam int HOLD_CYCLES  = 800;

   logic             clock = 0;
   logic             reset = 1;
   logic             req_valid = 0;
   logic             req_stall;
   hfe_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1;
   hfe_pkg::rsp_type rsp_data;
   logic             csr_valid = 0;
   logic             csr_ready;
   logic [6:0]       csr_data = '0;

   hermite_scoreboard points = new();
   int send_pct = 29;
   int recv_pct = 83;
   int hold_asked = 0;
   int hold_served = 0;
   int hold_left = 0;
   int quiet_cycles = 0;

   hermite_function_evaluator_core i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) points.check_result(rsp_data);
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1;
      end else if (hold_served < hold_asked) begin
         hold_served++;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb_hermite_function_evaluator_core: errors");
         $finish;
      end
   end

   task automatic send_point(logic signed [23:0] x, logic fin);
      hfe_pkg::req_type r;
      r.x_point    = x;
      r.last_point = fin;
      while ($urandom_range(99) < send_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_data  <= r;
      do @(posedge clock); while (req_stall !== 1'b0);
      points.note_request(r);
   endtask

   task automatic wait_idle();
      req_valid <= 0;
      do @(posedge clock); while (points.pending.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_orders(logic [6:0] v);
      csr_valid <= 1;
      csr_data  <= v;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 0;
      points.orders = v;
   endtask

   function automatic logic signed [23:0] pick_point();
      int sel;
      sel = $urandom_range(9);
      if (sel < 5) return 24'($signed($urandom_range(3670016)) - 1835008);
      if (sel < 8) return 24'($signed($urandom_range(1572864)) - 786432);
      return 24'($urandom);
   endfunction

   initial begin
      logic signed [23:0] edge_points[20];
      int orders_set[8];
      int counts[8];
      edge_points = '{24'sd0, -24'sd8388608, 24'sd8388607, 24'sd1, -24'sd1,
                      24'sd262144, -24'sd262144, 24'sd524288, -24'sd524288,
                      24'sd1738876, 24'sd1738877, 24'sd1738878, 24'sd1738879,
                      -24'sd1738877, -24'sd1738878, -24'sd1738879, 24'sd1048576,
                      -24'sd1572864, 24'sd4194304, 24'sd131072};
      orders_set = '{1, 127, 0, 7, 64, 2, 33, 12};
      counts     = '{50, 15, 50, 60, 15, 60, 30, 60};
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (edge_points[i]) send_point(edge_points[i], i[0]);
      for (int ph = 0; ph < 8; ph++) begin
         wait_idle();
         if (ph == 3) begin
            send_pct = 83;
            recv_pct = 29;
         end else if (ph == 6) begin
            send_pct = 0;
            recv_pct = 0;
         end
         write_orders(orders_set[ph][6:0]);
         for (int i = 0; i < counts[ph]; i++) begin
            if (ph == 5 && i == 5) hold_asked++;
            send_point(pick_point(), $urandom_range(1));
         end
      end
      wait_idle();
      if (points.errors == 0)
         $display("tb_hermite_function_evaluator_core: clean");
      else
         $display("tb_hermite_function_evaluator_core: errors");
      $finish;
   end
endmodule
